@@ rtl/core/mlat_pkg.sv @@
// ----------------------------------------------------------------------------
// mlat_pkg
// Shared codes, command/status bundles and time compare for the listener table.
// ----------------------------------------------------------------------------
package mlat_pkg;

    localparam int MAX_LISTENERS_DEF = 64;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ADDED   = 2'd1;
    localparam logic [1:0] EV_REMOVED = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // event address source
    localparam logic [1:0] ASEL_ZERO  = 2'd0;
    localparam logic [1:0] ASEL_INPUT = 2'd1;
    localparam logic [1:0] ASEL_EVENT = 2'd2;

    localparam logic [31:0] TIME_FAR = 32'h7fff_ffff;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       rd_last;
        logic       wr_addr;
        logic       wr_exp;
        logic       wr_at_count;
        logic       wr_from_rd;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       idx_clr;
        logic       idx_inc;
        logic       arm;
        logic       tick_init;
        logic       tick_eval;
        logic       tick_set;
        logic       nexp_dec;
        logic       dl_clear;
        logic       latch_ev;
        logic       emit;
        logic [1:0] ev;
        logic [1:0] st;
        logic       fd;
        logic [1:0] asel;
        logic       last;
        logic       zero_dl;
    } mlat_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       addr_ok;
        logic       idx_eq_count;
        logic       match;
        logic       expired;
        logic       count_full;
        logic       count_zero;
        logic       nexp_zero;
        logic       out_free;
    } mlat_status_t;

    // a earlier than b on a wrapping 32-bit clock
    function automatic logic time_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

@@ rtl/core/mlat_datapath.sv @@
// ----------------------------------------------------------------------------
// mlat_datapath
// Entry memories, counters, deadline registers and the result register.
// ----------------------------------------------------------------------------
module mlat_datapath
    import mlat_pkg::*;
#(
    parameter int MAX_LISTENERS = MAX_LISTENERS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mlat_cmd_t          cmd,
    output mlat_status_t       stat,
    input  logic [2:0]         operation,
    input  logic [63:0]        address_high,
    input  logic [63:0]        address_low,
    input  logic [31:0]        expire_time,
    input  logic [31:0]        current_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         event_res,
    output logic [1:0]         status,
    output logic               found,
    output logic [63:0]        event_address_high,
    output logic [63:0]        event_address_low,
    output logic               deadline_armed,
    output logic [31:0]        next_deadline,
    output logic               last
);

    localparam int IW = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;
    localparam int CW = $clog2(MAX_LISTENERS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LISTENERS);

    logic [63:0] mem_hi  [MAX_LISTENERS];
    logic [63:0] mem_lo  [MAX_LISTENERS];
    logic [31:0] mem_exp [MAX_LISTENERS];

    logic [2:0]    op_reg;
    logic [63:0]   hi_reg, lo_reg;
    logic [31:0]   exp_reg, now_reg;
    logic [63:0]   rd_hi_reg, rd_lo_reg;
    logic [31:0]   rd_exp_reg;
    logic [63:0]   ev_hi_reg, ev_lo_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] nexp_reg, nexp_next;
    logic [31:0]   cand_reg, cand_next;
    logic [31:0]   dl_reg, dl_next;
    logic          dl_valid_reg, dl_valid_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] count_m1;
    logic [IW-1:0] rd_idx, wr_idx;
    logic [63:0]   wd_hi, wd_lo;
    logic [31:0]   wd_exp;
    logic          expired;
    logic [31:0]   far_time;
    logic          out_free;

    assign count_m1 = count_reg - 1'b1;
    assign rd_idx   = cmd.rd_last ? count_m1[IW-1:0] : idx_reg[IW-1:0];
    assign wr_idx   = cmd.wr_at_count ? count_reg[IW-1:0] : idx_reg[IW-1:0];
    assign wd_hi    = cmd.wr_from_rd ? rd_hi_reg : hi_reg;
    assign wd_lo    = cmd.wr_from_rd ? rd_lo_reg : lo_reg;
    assign wd_exp   = cmd.wr_from_rd ? rd_exp_reg : exp_reg;
    assign expired  = !time_before(now_reg, rd_exp_reg);
    assign far_time = now_reg + TIME_FAR;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_addr)
        begin
            mem_hi[wr_idx] <= wd_hi;
            mem_lo[wr_idx] <= wd_lo;
        end
        if (cmd.wr_exp)
        begin
            mem_exp[wr_idx] <= wd_exp;
        end
        if (cmd.rd_en)
        begin
            rd_hi_reg  <= mem_hi[rd_idx];
            rd_lo_reg  <= mem_lo[rd_idx];
            rd_exp_reg <= mem_exp[rd_idx];
        end
    end

    // captured request, event address and result outputs, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            hi_reg  <= address_high;
            lo_reg  <= address_low;
            exp_reg <= expire_time;
            now_reg <= current_time;
        end
        if (cmd.latch_ev)
        begin
            ev_hi_reg <= rd_hi_reg;
            ev_lo_reg <= rd_lo_reg;
        end
        if (cmd.emit)
        begin
            event_res <= cmd.ev;
            status    <= cmd.st;
            found     <= cmd.fd;
            last      <= cmd.last;
            unique case (cmd.asel)
                ASEL_INPUT:
                begin
                    event_address_high <= hi_reg;
                    event_address_low  <= lo_reg;
                end
                ASEL_EVENT:
                begin
                    event_address_high <= ev_hi_reg;
                    event_address_low  <= ev_lo_reg;
                end
                default:
                begin
                    event_address_high <= '0;
                    event_address_low  <= '0;
                end
            endcase
            deadline_armed <= cmd.zero_dl ? 1'b0 : dl_valid_reg;
            next_deadline  <= (cmd.zero_dl || !dl_valid_reg) ? 32'd0 : dl_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        nexp_next      = nexp_reg;
        cand_next      = cand_reg;
        dl_next        = dl_reg;
        dl_valid_next  = dl_valid_reg;
        out_valid_next = out_valid_reg;

        if (cmd.cnt_inc)
            count_next = count_reg + 1'b1;
        else if (cmd.cnt_dec)
            count_next = count_m1;

        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;

        if (cmd.tick_init)
        begin
            nexp_next = '0;
            cand_next = far_time;
        end
        else if (cmd.tick_eval)
        begin
            if (expired)
                nexp_next = nexp_reg + 1'b1;
            else if (time_before(rd_exp_reg, cand_reg))
                cand_next = rd_exp_reg;
        end
        else if (cmd.nexp_dec)
        begin
            nexp_next = nexp_reg - 1'b1;
        end

        if (cmd.arm)
        begin
            if (!dl_valid_reg || time_before(exp_reg, dl_reg))
            begin
                dl_next       = exp_reg;
                dl_valid_next = 1'b1;
            end
        end
        else if (cmd.tick_set)
        begin
            dl_valid_next = (cand_reg != far_time);
            dl_next       = (cand_reg != far_time) ? cand_reg : 32'd0;
        end
        else if (cmd.dl_clear)
        begin
            dl_valid_next = 1'b0;
            dl_next       = 32'd0;
        end

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            nexp_reg      <= '0;
            cand_reg      <= '0;
            dl_reg        <= '0;
            dl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            nexp_reg      <= nexp_next;
            cand_reg      <= cand_next;
            dl_reg        <= dl_next;
            dl_valid_reg  <= dl_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        stat.op           = op_reg;
        stat.addr_ok      = (hi_reg[63:56] == 8'hff) && (hi_reg[51:48] > 4'd3);
        stat.idx_eq_count = (idx_reg == count_reg);
        stat.match        = (rd_hi_reg == hi_reg) && (rd_lo_reg == lo_reg);
        stat.expired      = expired;
        stat.count_full   = (count_reg == CNT_MAX);
        stat.count_zero   = (count_reg == '0);
        stat.nexp_zero    = (nexp_reg == '0);
        stat.out_free     = out_free;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count above table size");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over an untaken beat");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> count_reg != '0)
        else $error("entry count underflow");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> count_reg != CNT_MAX)
        else $error("append into full table");

    a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !dl_valid_reg |-> dl_reg == 32'd0)
        else $error("disarmed deadline not zero");

endmodule

@@ rtl/core/mlat_controller.sv @@
// ----------------------------------------------------------------------------
// mlat_controller
// Sequencer for search, append, remove, expiry scan and clear.
// ----------------------------------------------------------------------------
module mlat_controller
    import mlat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  mlat_status_t stat,
    output mlat_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_RD     = 5'd2;
    localparam logic [4:0] S_CMP    = 5'd3;
    localparam logic [4:0] S_R_RD   = 5'd4;
    localparam logic [4:0] S_R_MV   = 5'd5;
    localparam logic [4:0] S_T1_RD  = 5'd6;
    localparam logic [4:0] S_T1_CHK = 5'd7;
    localparam logic [4:0] S_T1_END = 5'd8;
    localparam logic [4:0] S_T2_RD  = 5'd9;
    localparam logic [4:0] S_T2_CHK = 5'd10;
    localparam logic [4:0] S_T2_LRD = 5'd11;
    localparam logic [4:0] S_T2_MV  = 5'd12;
    localparam logic [4:0] S_T2_EMT = 5'd13;
    localparam logic [4:0] S_C_RD   = 5'd14;
    localparam logic [4:0] S_C_LAT  = 5'd15;
    localparam logic [4:0] S_C_EMT  = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [1:0] res_ev_reg, res_ev_next;
    logic [1:0] res_st_reg, res_st_next;
    logic       res_fd_reg, res_fd_next;
    logic [1:0] res_asel_reg, res_asel_next;
    logic       res_zdl_reg, res_zdl_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        res_ev_next   = res_ev_reg;
        res_st_next   = res_st_reg;
        res_fd_next   = res_fd_reg;
        res_asel_next = res_asel_reg;
        res_zdl_next  = res_zdl_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                res_ev_next   = EV_NONE;
                res_st_next   = ST_OK;
                res_fd_next   = 1'b0;
                res_asel_next = ASEL_ZERO;
                res_zdl_next  = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority case (stat.op)
                    OP_ADD:
                    begin
                        if (!stat.addr_ok)
                        begin
                            res_st_next = ST_INVALID;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    OP_REMOVE, OP_LOOKUP:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_RD;
                    end
                    OP_TICK:
                    begin
                        cmd.idx_clr   = 1'b1;
                        cmd.tick_init = 1'b1;
                        state_next    = S_T1_RD;
                    end
                    OP_CLEAR:
                    begin
                        cmd.dl_clear = 1'b1;
                        state_next   = stat.count_zero ? S_EMIT : S_C_RD;
                    end
                    default:
                    begin
                        res_zdl_next = 1'b1;
                        state_next   = S_EMIT;
                    end
                endcase
            end
            S_RD:
            begin
                if (stat.idx_eq_count)
                begin
                    state_next = S_EMIT;
                    priority case (stat.op)
                        OP_ADD:
                        begin
                            if (stat.count_full)
                            begin
                                res_st_next = ST_NO_SPACE;
                            end
                            else
                            begin
                                cmd.wr_addr     = 1'b1;
                                cmd.wr_exp      = 1'b1;
                                cmd.wr_at_count = 1'b1;
                                cmd.cnt_inc     = 1'b1;
                                cmd.arm         = 1'b1;
                                res_ev_next     = EV_ADDED;
                                res_asel_next   = ASEL_INPUT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            res_st_next = ST_NOTFOUND;
                        end
                        default:
                        begin
                            res_fd_next = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    priority case (stat.op)
                        OP_ADD:
                        begin
                            cmd.wr_exp = 1'b1;
                            cmd.arm    = 1'b1;
                            state_next = S_EMIT;
                        end
                        OP_REMOVE:
                        begin
                            state_next = S_R_RD;
                        end
                        default:
                        begin
                            res_fd_next = 1'b1;
                            state_next  = S_EMIT;
                        end
                    endcase
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_R_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = 1'b1;
                state_next  = S_R_MV;
            end
            S_R_MV:
            begin
                // last entry fills the hole
                cmd.wr_addr    = 1'b1;
                cmd.wr_exp     = 1'b1;
                cmd.wr_from_rd = 1'b1;
                cmd.cnt_dec    = 1'b1;
                res_ev_next    = EV_REMOVED;
                res_asel_next  = ASEL_INPUT;
                state_next     = S_EMIT;
            end
            S_T1_RD:
            begin
                if (stat.idx_eq_count)
                begin
                    state_next = S_T1_END;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_T1_CHK;
                end
            end
            S_T1_CHK:
            begin
                cmd.tick_eval = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = S_T1_RD;
            end
            S_T1_END:
            begin
                cmd.tick_set = 1'b1;
                cmd.idx_clr  = 1'b1;
                state_next   = stat.nexp_zero ? S_EMIT : S_T2_RD;
            end
            S_T2_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_T2_CHK;
            end
            S_T2_CHK:
            begin
                if (stat.expired)
                begin
                    cmd.latch_ev = 1'b1;
                    cmd.nexp_dec = 1'b1;
                    state_next   = S_T2_LRD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_T2_RD;
                end
            end
            S_T2_LRD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = 1'b1;
                state_next  = S_T2_MV;
            end
            S_T2_MV:
            begin
                cmd.wr_addr    = 1'b1;
                cmd.wr_exp     = 1'b1;
                cmd.wr_from_rd = 1'b1;
                cmd.cnt_dec    = 1'b1;
                state_next     = S_T2_EMT;
            end
            S_T2_EMT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = EV_REMOVED;
                    cmd.st     = ST_OK;
                    cmd.asel   = ASEL_EVENT;
                    cmd.last   = stat.nexp_zero;
                    state_next = stat.nexp_zero ? S_IDLE : S_T2_RD;
                end
            end
            S_C_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_last = 1'b1;
                state_next  = S_C_LAT;
            end
            S_C_LAT:
            begin
                cmd.latch_ev = 1'b1;
                cmd.cnt_dec  = 1'b1;
                state_next   = S_C_EMT;
            end
            S_C_EMT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = EV_REMOVED;
                    cmd.st     = ST_OK;
                    cmd.asel   = ASEL_EVENT;
                    cmd.last   = stat.count_zero;
                    state_next = stat.count_zero ? S_IDLE : S_C_RD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.ev      = res_ev_reg;
                    cmd.st      = res_st_reg;
                    cmd.fd      = res_fd_reg;
                    cmd.asel    = res_asel_reg;
                    cmd.zero_dl = res_zdl_reg;
                    cmd.last    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            res_ev_reg   <= EV_NONE;
            res_st_reg   <= ST_OK;
            res_fd_reg   <= 1'b0;
            res_asel_reg <= ASEL_ZERO;
            res_zdl_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_ev_reg   <= res_ev_next;
            res_st_reg   <= res_st_next;
            res_fd_reg   <= res_fd_next;
            res_asel_reg <= res_asel_next;
            res_zdl_reg  <= res_zdl_next;
        end
    end

endmodule

@@ rtl/core/multicast_listener_aging_table.sv @@
// ----------------------------------------------------------------------------
// multicast_listener_aging_table
// Bounded multicast listener table with expiry aging, one request at a time.
// ----------------------------------------------------------------------------
// Steps: add/remove/lookup read and compare the entries one by one, then
// answer; a rejected address or an unused code answers without a scan.
// Tick: one pass over all entries finds the new deadline, then a second pass
// removes the expired entries (one beat each). Clear: one beat per entry.
// One request in flight; the next is taken after its last beat is loaded.
// Reset clears count and deadline at once; entry memories are not cleared.
// ----------------------------------------------------------------------------
module multicast_listener_aging_table
    import mlat_pkg::*;
#(
    parameter int MAX_LISTENERS = MAX_LISTENERS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [63:0] address_high,
    input  logic [63:0] address_low,
    input  logic [31:0] expire_time,
    input  logic [31:0] current_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [1:0]  status,
    output logic        found,
    output logic [63:0] event_address_high,
    output logic [63:0] event_address_low,
    output logic        deadline_armed,
    output logic [31:0] next_deadline,
    output logic        last
);

    mlat_cmd_t    cmd;
    mlat_status_t stat;

    mlat_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlat_datapath #(
        .MAX_LISTENERS (MAX_LISTENERS)
    ) u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .operation          (operation),
        .address_high       (address_high),
        .address_low        (address_low),
        .expire_time        (expire_time),
        .current_time       (current_time),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .event_res          (event_res),
        .status             (status),
        .found              (found),
        .event_address_high (event_address_high),
        .event_address_low  (event_address_low),
        .deadline_armed     (deadline_armed),
        .next_deadline      (next_deadline),
        .last               (last)
    );

endmodule
